>>> design/hsi_pkg.sv
// Shared types, constants and codes for the hash-to-shard-index block.
// No dependencies; every other design file imports this package.
package hsi_pkg;

    localparam int VALUE_BITS = 64;
    localparam int COUNT_BITS = 16;
    localparam int CELL_BITS  = 8;
    localparam int NUM_CELLS  = VALUE_BITS / CELL_BITS;
    localparam int PART_BITS  = VALUE_BITS / 2;
    localparam int PPROD_BITS = PART_BITS + COUNT_BITS;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [VALUE_BITS-1:0] INT64_TOP = {1'b0, {(VALUE_BITS-1){1'b1}}};

    localparam logic [1:0] MODE_VERBATIM = 2'd0;
    localparam logic [1:0] MODE_MODULO   = 2'd1;
    localparam logic [1:0] MODE_RANGE    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [1:0] mode;
        count_t     count;
    } cfg_t;

    // Per-request payload that travels down the divider chain.
    typedef struct packed {
        logic [1:0]            pre_status;
        count_t                verb_idx;
        value_t                value;
        count_t                rem_a;
        count_t                rem_b;
        logic [PPROD_BITS-1:0] prod_hi;
        logic [PPROD_BITS-1:0] prod_lo;
    } cell_data_t;

endpackage

>>> design/hash_to_shard_index.sv
// Top level of the hash-to-shard-index block: input stage, divider cell chain,
// range correction multiply and output register. Depends on hsi_pkg, hsi_cfg, hsi_cell.
//
//   channel   ports                                       handshake
//   request   start, busy, route_value, value_valid       start & !busy
//   result    done, shard_index, route_status             done, one cycle, no stall
//   config    psel, penable, pwrite, paddr, pwdata,       APB, pready tied high
//             prdata, pready
//
// One request per cycle; busy stays low. Each request's done pulse comes out through
// eleven register stages: input stage, eight divider cells of eight bits each, the
// range-correction multiply stage and the output register.
// Reset clears the pipeline valid bits and sets route_mode 0, shard_count 1.
// The result side cannot stall; results leave in request order.
module hash_to_shard_index (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hsi_pkg::VALUE_BITS-1:0]      route_value,
    input  logic                                value_valid,
    output logic                                done,
    output logic [hsi_pkg::COUNT_BITS-1:0]      shard_index,
    output logic [1:0]                          route_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsi_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [hsi_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [hsi_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import hsi_pkg::*;

    cfg_t       cfg;
    logic       accept;
    logic [PPROD_BITS-1:0] in_prod_lo;
    logic [PPROD_BITS-1:0] in_prod_hi;
    logic       in_vld_reg;
    cell_data_t in_data_reg;
    cell_data_t in_data_next;

    logic       cell_vld [NUM_CELLS+1];
    cell_data_t cell_data [NUM_CELLS+1];

    cell_data_t chain_out;
    count_t     rem_comp;
    logic [PPROD_BITS-1:0] prod_sum;
    count_t     prod_h_next;
    value_t     prod_l_next;
    count_t     prod_h_reg;
    value_t     prod_l_reg;
    logic [2*COUNT_BITS-1:0] mul_prod_next;
    logic [2*COUNT_BITS-1:0] mul_prod_reg;
    logic       mul_vld_reg;
    cell_data_t mul_data_reg;

    logic       done_reg;
    count_t     idx_reg;
    count_t     idx_next;
    logic [1:0] status_reg;

    hsi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Input stage: early status checks and the two half products of value * count.
    assign in_prod_lo = PPROD_BITS'(route_value[PART_BITS-1:0]) * PPROD_BITS'(cfg.count);
    assign in_prod_hi = PPROD_BITS'(route_value[VALUE_BITS-1:PART_BITS])
                        * PPROD_BITS'(cfg.count);

    always_comb
    begin
        in_data_next.value    = route_value;
        in_data_next.verb_idx = route_value[COUNT_BITS-1:0];
        in_data_next.rem_a    = '0;
        in_data_next.rem_b    = count_t'(1);
        in_data_next.prod_hi  = in_prod_hi;
        in_data_next.prod_lo  = in_prod_lo;
        if (!value_valid)
            in_data_next.pre_status = ST_INVALID;
        else if (cfg.mode == MODE_VERBATIM)
        begin
            if (route_value > INT64_TOP)
                in_data_next.pre_status = ST_TOO_BIG;
            else if (route_value >= VALUE_BITS'(cfg.count))
                in_data_next.pre_status = ST_RANGE;
            else
                in_data_next.pre_status = ST_OK;
        end
        else if (cfg.count == '0)
            in_data_next.pre_status = ST_RANGE;
        else
            in_data_next.pre_status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign cell_vld[0]  = in_vld_reg;
    assign cell_data[0] = in_data_reg;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        hsi_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (cfg.count),
            .vld_in   (cell_vld[g]),
            .data_in  (cell_data[g]),
            .vld_out  (cell_vld[g+1]),
            .data_out (cell_data[g+1])
        );
    end

    // Range mode: width = ceil(2^64/c); idx = H, or H-1 when H*r' > L,
    // with r' = (-2^64) mod c and v*c = H:L.
    assign chain_out = cell_data[NUM_CELLS];
    assign rem_comp  = (chain_out.rem_b == '0) ? '0 : cfg.count - chain_out.rem_b;
    // join the half products into H:L; the sum stays below 2^48
    assign prod_sum    = chain_out.prod_hi
                         + PPROD_BITS'(chain_out.prod_lo[PPROD_BITS-1:PART_BITS]);
    assign prod_h_next = prod_sum[PPROD_BITS-1:PART_BITS];
    assign prod_l_next = {prod_sum[PART_BITS-1:0], chain_out.prod_lo[PART_BITS-1:0]};
    assign mul_prod_next = (2*COUNT_BITS)'(prod_h_next) * (2*COUNT_BITS)'(rem_comp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= cell_vld[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        mul_data_reg <= chain_out;
        mul_prod_reg <= mul_prod_next;
        prod_h_reg   <= prod_h_next;
        prod_l_reg   <= prod_l_next;
    end

    always_comb
    begin
        if (mul_data_reg.pre_status != ST_OK)
            idx_next = '0;
        else if (cfg.mode == MODE_VERBATIM)
            idx_next = mul_data_reg.verb_idx;
        else if (cfg.mode == MODE_MODULO)
            idx_next = mul_data_reg.rem_a;
        else if (cfg.count == count_t'(1))
            idx_next = '0;
        else if (VALUE_BITS'(mul_prod_reg) <= prod_l_reg)
            idx_next = prod_h_reg;
        else
            idx_next = prod_h_reg - count_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= mul_data_reg.pre_status;
    end

    assign done         = done_reg;
    assign shard_index  = idx_reg;
    assign route_status = status_reg;

endmodule

>>> design/hsi_cfg.sv
// APB-style configuration registers: route mode and shard count.
// Depends on hsi_pkg.
module hsi_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsi_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [hsi_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [hsi_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output hsi_pkg::cfg_t                       cfg
);
    import hsi_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    count_t     count_reg;
    count_t     count_next;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:  mode_next  = pwdata[1:0];
                REG_COUNT: count_next = pwdata[COUNT_BITS-1:0];
                default:   mode_next  = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_VERBATIM;
            count_reg <= count_t'(1);
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:  prdata = APB_DATA_BITS'(mode_reg);
            REG_COUNT: prdata = APB_DATA_BITS'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.mode  = mode_reg;
    assign cfg.count = count_reg;

endmodule

>>> design/hsi_cell.sv
// One divider cell: CELL_BITS restoring remainder steps on two lanes.
// Lane A reduces the routing value, lane B reduces 2^64. Depends on hsi_pkg.
module hsi_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  hsi_pkg::count_t     count,
    input  logic                vld_in,
    input  hsi_pkg::cell_data_t data_in,
    output logic                vld_out,
    output hsi_pkg::cell_data_t data_out
);
    import hsi_pkg::*;

    logic       vld_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        logic [COUNT_BITS:0] ta;
        logic [COUNT_BITS:0] tb;
        count_t              ra;
        count_t              rb;
        data_next = data_in;
        ra = data_in.rem_a;
        rb = data_in.rem_b;
        for (int i = 0; i < CELL_BITS; i++)
        begin
            ta = {ra, data_in.value[VALUE_BITS-1-i]};
            if (ta >= {1'b0, count})
                ta = ta - {1'b0, count};
            ra = ta[COUNT_BITS-1:0];
            tb = {rb, 1'b0};
            if (tb >= {1'b0, count})
                tb = tb - {1'b0, count};
            rb = tb[COUNT_BITS-1:0];
        end
        data_next.rem_a = ra;
        data_next.rem_b = rb;
        // advance to the next slice of the value
        data_next.value = data_in.value << CELL_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

>>> test/hash_to_shard_index_tb.sv
// Self-checking testbench for hash_to_shard_index: directed and random routing
// requests under several mode/count settings, checked against a local predictor.
// Depends on hsi_pkg and the hash_to_shard_index RTL.
`timescale 1ns / 1ps

module hash_to_shard_index_tb;
    import hsi_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam value_t     ALL_ONES   = {VALUE_BITS{1'b1}};
    localparam int         IDLE_LIMIT = 600;
    localparam int         PHASE_ITEMS = 150;
    localparam int         NUM_PHASES  = 13;

    typedef struct packed {
        count_t     index;
        logic [1:0] status;
    } route_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    value_t                    route_value = '0;
    logic                      value_valid = 1'b0;
    logic                      done;
    count_t                    shard_index;
    logic [1:0]                route_status;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // Local copy of the configuration registers.
    logic [1:0]     cfg_mode = MODE_VERBATIM;
    count_t         cfg_count = count_t'(1);

    route_result_t  expected_routes[$];
    int             errors = 0;
    int             burst_left = 0;

    hash_to_shard_index dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .route_value  (route_value),
        .value_valid  (value_valid),
        .done         (done),
        .shard_index  (shard_index),
        .route_status (route_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic route_result_t predict_shard(value_t v, logic ok);
        route_result_t r;
        value_t        count64;
        value_t        span;
        value_t        idx;
        r.index  = '0;
        r.status = ST_OK;
        count64  = value_t'(cfg_count);
        idx      = '0;
        if (!ok)
        begin
            r.status = ST_INVALID;
        end
        else if (cfg_mode == MODE_VERBATIM)
        begin
            if (v > INT64_TOP)
                r.status = ST_TOO_BIG;
            else if (v >= count64)
                r.status = ST_RANGE;
            else
                r.index = v[COUNT_BITS-1:0];
        end
        else if (cfg_count == '0)
        begin
            r.status = ST_RANGE;
        end
        else
        begin
            if (cfg_mode == MODE_MODULO)
                idx = v % count64;
            else if (count64 < 2)
                idx = '0;
            else
            begin
                span = ALL_ONES / count64 + 64'd1;
                idx  = v / span;
            end
            if (idx >= count64)
                r.status = ST_RANGE;
            else
                r.index = idx[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    // Values biased toward the edges that matter for the current count.
    function automatic value_t rand_value(count_t count);
        value_t      span;
        value_t      v;
        int unsigned top;
        top  = 32'(count) + 32'd2;
        span = (count < 2) ? 64'd0 : (ALL_ONES / value_t'(count) + 64'd1);
        case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1: v = value_t'($urandom_range(0, top));
            2: v = ALL_ONES - value_t'($urandom_range(0, 3));
            3: v = INT64_TOP + value_t'($urandom_range(0, 3)) - 64'd1;
            default:
                v = span * value_t'($urandom_range(0, count))
                    + value_t'($urandom_range(0, 2)) - 64'd1;
        endcase
        return v;
    endfunction

    task automatic send_request(value_t v, logic ok);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        start       <= 1'b1;
        route_value <= v;
        value_valid <= ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_routes = {expected_routes, predict_shard(v, ok)};
        burst_left--;
    endtask

    // Stop sending and wait for every outstanding request to come back.
    task automatic drain_requests();
        start <= 1'b0;
        burst_left = 0;
        while (expected_routes.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic reg_idx, logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_idx == REG_MODE)
            cfg_mode = data[1:0];
        else
            cfg_count = data[COUNT_BITS-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(logic reg_idx, logic [APB_DATA_BITS-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata expected %0h actual %0h", want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Junk in the upper bits of each write must be masked off.
    task automatic set_route(logic [1:0] mode, count_t count);
        logic [APB_DATA_BITS-1:0] junk;
        drain_requests();
        junk = $urandom;
        apb_write(REG_MODE, {junk[31:2], mode});
        apb_read(REG_MODE, {30'd0, mode});
        junk = $urandom;
        apb_write(REG_COUNT, {junk[31:16], count});
        apb_read(REG_COUNT, {16'd0, count});
    endtask

    task automatic test_reset_defaults();
        apb_read(REG_MODE, {30'd0, MODE_VERBATIM});
        apb_read(REG_COUNT, 32'd1);
        send_request(64'd0, 1'b1);
        send_request(64'd1, 1'b1);
    endtask

    task automatic test_verbatim();
        set_route(MODE_VERBATIM, 16'hFFFF);
        send_request(64'd0, 1'b1);
        send_request(64'd65534, 1'b1);
        send_request(64'd65535, 1'b1);
        send_request(INT64_TOP, 1'b1);
        send_request(INT64_TOP + 64'd1, 1'b1);
        send_request(ALL_ONES, 1'b1);
        send_request(64'd5, 1'b0);
    endtask

    task automatic test_modulo();
        set_route(MODE_MODULO, 16'hFFFF);
        send_request(64'd0, 1'b1);
        send_request(ALL_ONES, 1'b1);
        send_request(64'd65535, 1'b1);
        set_route(MODE_MODULO, 16'd1);
        send_request(ALL_ONES, 1'b1);
    endtask

    task automatic test_range();
        value_t span;
        span = ALL_ONES / 64'd3 + 64'd1;
        set_route(MODE_RANGE, 16'd3);
        send_request(64'd0, 1'b1);
        send_request(span - 64'd1, 1'b1);
        send_request(span, 1'b1);
        send_request(ALL_ONES, 1'b1);
        set_route(MODE_RANGE, 16'd1);
        send_request(ALL_ONES, 1'b1);
        // spare mode code routes like range mode
        set_route(MODE_SPARE, 16'hFFFF);
        send_request(ALL_ONES, 1'b1);
        send_request(64'd0, 1'b1);
    endtask

    task automatic test_zero_count();
        set_route(MODE_VERBATIM, 16'd0);
        send_request(64'd0, 1'b1);
        send_request(INT64_TOP + 64'd1, 1'b1);
        set_route(MODE_MODULO, 16'd0);
        send_request(64'd7, 1'b1);
        send_request(64'd7, 1'b0);
        set_route(MODE_RANGE, 16'd0);
        send_request(64'd7, 1'b1);
    endtask

    task automatic test_random_phases();
        count_t count;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case ($urandom_range(0, 7))
                0: count = 16'd0;
                1: count = 16'd1;
                2: count = 16'd2;
                3: count = 16'hFFFF;
                4: count = 16'hFFFE;
                5: count = count_t'(1) << $urandom_range(0, COUNT_BITS - 1);
                6: count = count_t'($urandom_range(3, 40));
                default: count = count_t'($urandom);
            endcase
            set_route(p[1:0], count);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(rand_value(count), $urandom_range(0, 9) != 0);
        end
    endtask

    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && done)
        begin
            if (expected_routes.size() == 0)
            begin
                $error("unexpected result shard_index %0d route_status %0d",
                       shard_index, route_status);
                errors++;
            end
            else
            begin
                want = expected_routes.pop_front();
                if (shard_index !== want.index)
                begin
                    $error("shard_index expected %0d actual %0d", want.index, shard_index);
                    errors++;
                end
                if (route_status !== want.status)
                begin
                    $error("route_status expected %0d actual %0d",
                           want.status, route_status);
                    errors++;
                end
            end
        end
    end

    // Abort when nothing moves on any port for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL hash_to_shard_index");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_verbatim();
        test_modulo();
        test_range();
        test_zero_count();
        test_random_phases();
        drain_requests();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS hash_to_shard_index");
        else
            $display("FAIL hash_to_shard_index");
        $finish;
    end

endmodule
